### hdl/bptc_pkg.sv
package bptc_pkg;

   // datapath word width and divider depth
   localparam int DIV_W = 32;

   // configuration register indexes
   localparam logic [2:0] CSR_A1    = 3'd0;
   localparam logic [2:0] CSR_A2    = 3'd1;
   localparam logic [2:0] CSR_A3    = 3'd2;
   localparam logic [2:0] CSR_A4    = 3'd3;
   localparam logic [2:0] CSR_A5_A6 = 3'd4;
   localparam logic [2:0] CSR_B1_B2 = 3'd5;
   localparam logic [2:0] CSR_C_D   = 3'd6;
   localparam logic [2:0] CSR_OSS   = 3'd7;

   // compensation constants
   localparam logic [31:0] B6_OFFSET  = 32'd4000;
   localparam logic [31:0] TRIM_SQ    = 32'd3038;
   localparam logic [31:0] TRIM_LIN   = 32'hFFFF_E343;   // -7357
   localparam logic [31:0] TRIM_OFS   = 32'd3791;
   localparam logic [31:0] B7_SCALE   = 32'd50000;
   localparam logic [31:0] B4_BIAS    = 32'd32768;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } req_data_type;

   typedef struct packed {
      logic signed [27:0] temperature;
      logic signed [31:0] pressure;
      logic               divide_error;
   } rsp_data_type;

   // arithmetic right shift of a 32-bit word
   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
      return 32'($signed(x) >>> s);
   endfunction

   // sign extend a 16-bit field
   function automatic logic [31:0] sx16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

endpackage

### hdl/baro_temp_pressure_compensation_core.sv
// Integer barometric compensation: one raw temperature / raw pressure pair may be
// started in every cycle (busy stays low), and its result shows on rsp_valid for one
// cycle. The result path runs through two 32-stage pipelined dividers (temperature
// term and pressure) plus the multiply stages around them.
// Results come out in start order and cannot be held off, so the receiver must take
// each one in its cycle. A zero divisor gives zero results with divide_error set.
// Coefficients are read live by the stages that use them: write them only while nothing is in flight.
module baro_temp_pressure_compensation_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bptc_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   output bptc_pkg::rsp_data_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import bptc_pkg::*;

   localparam int LATENCY = 75;
   localparam int D1_SIDE = 53;
   localparam int D2_SIDE = 30;

   // configuration registers
   logic [15:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [31:0] a5a6_ff, b1b2_ff, cd_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff   <= '0;
         a2_ff   <= '0;
         a3_ff   <= '0;
         a4_ff   <= '0;
         a5a6_ff <= '0;
         b1b2_ff <= '0;
         cd_ff   <= '0;
         oss_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_A1:    a1_ff   <= csr_wdata[15:0];
            CSR_A2:    a2_ff   <= csr_wdata[15:0];
            CSR_A3:    a3_ff   <= csr_wdata[15:0];
            CSR_A4:    a4_ff   <= csr_wdata[15:0];
            CSR_A5_A6: a5a6_ff <= csr_wdata;
            CSR_B1_B2: b1b2_ff <= csr_wdata;
            CSR_C_D:   cd_ff   <= csr_wdata;
            CSR_OSS:   oss_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [31:0] a1, a2, a3, a4, a5, a6, b1, b2, mc, md;
   assign a1 = sx16(a1_ff);
   assign a2 = sx16(a2_ff);
   assign a3 = sx16(a3_ff);
   assign a4 = {16'd0, a4_ff};
   assign a5 = {16'd0, a5a6_ff[31:16]};
   assign a6 = {16'd0, a5a6_ff[15:0]};
   assign b1 = sx16(b1b2_ff[31:16]);
   assign b2 = sx16(b1b2_ff[15:0]);
   assign mc = sx16(cd_ff[31:16]);
   assign md = sx16(cd_ff[15:0]);

   assign busy = 1'b0;

   // stage valid bits
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v9_ff, v10_ff, rsp_valid_ff;
   logic d1_valid, d2_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= start && !busy;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= d1_valid;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= d2_valid;
         v10_ff       <= v9_ff;
         rsp_valid_ff <= v10_ff;
      end
   end

   // input capture
   logic [15:0] ut0_ff;
   logic [18:0] up0_ff;
   always_ff @(posedge clock) begin
      ut0_ff <= req_data.raw_temp;
      up0_ff <= req_data.raw_pressure;
   end

   // temperature slope product
   logic [31:0] prod1_ff;
   logic [18:0] up1_ff;
   always_ff @(posedge clock) begin
      prod1_ff <= 32'(({16'd0, ut0_ff} - a6) * a5);
      up1_ff   <= up0_ff;
   end

   // temperature divider operands
   logic [31:0] x1_2, den2, num2;
   logic [31:0] x1_2_ff, magn2_ff, magd2_ff;
   logic [18:0] up2_ff;
   logic        neg2_ff, err2_ff;
   assign x1_2 = asr(prod1_ff, 5'd15);
   assign den2 = x1_2 + md;
   assign num2 = mc << 11;
   always_ff @(posedge clock) begin
      x1_2_ff  <= x1_2;
      up2_ff   <= up1_ff;
      magn2_ff <= num2[31] ? 32'(0 - num2) : num2;
      magd2_ff <= den2[31] ? 32'(0 - den2) : den2;
      neg2_ff  <= num2[31] ^ den2[31];
      err2_ff  <= den2 == '0;
   end

   logic [31:0]        q1;
   logic [D1_SIDE-1:0] s1;
   bptc_div #(.SIDE_W(D1_SIDE)) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_num    (magn2_ff),
      .in_den    (magd2_ff),
      .in_side   ({x1_2_ff, up2_ff, neg2_ff, err2_ff}),
      .out_valid (d1_valid),
      .out_quo   (q1),
      .out_side  (s1)
   );

   // b5, temperature and b6
   logic [31:0] x2_3, b5_3, t3;
   logic [31:0] b6_3_ff;
   logic [27:0] temp3_ff;
   logic [18:0] up3_ff;
   logic        err3_ff;
   assign x2_3 = s1[1] ? 32'(0 - q1) : q1;
   assign b5_3 = s1[52:21] + x2_3;
   assign t3   = asr(b5_3 + 32'd8, 5'd4);
   always_ff @(posedge clock) begin
      temp3_ff <= t3[27:0];
      b6_3_ff  <= b5_3 - B6_OFFSET;
      up3_ff   <= s1[20:2];
      err3_ff  <= s1[0];
   end

   // first products of b6
   logic [31:0] sq4_ff, a2b6_4_ff, a3b6_4_ff;
   logic [27:0] temp4_ff;
   logic [18:0] up4_ff;
   logic        err4_ff;
   always_ff @(posedge clock) begin
      sq4_ff    <= 32'(b6_3_ff * b6_3_ff);
      a2b6_4_ff <= 32'(a2 * b6_3_ff);
      a3b6_4_ff <= 32'(a3 * b6_3_ff);
      temp4_ff  <= temp3_ff;
      up4_ff    <= up3_ff;
      err4_ff   <= err3_ff;
   end

   // quadratic terms
   logic [31:0] b6sq5;
   logic [31:0] b2sq5_ff, b1sq5_ff, a2b6_5_ff, a3b6_5_ff;
   logic [27:0] temp5_ff;
   logic [18:0] up5_ff;
   logic        err5_ff;
   assign b6sq5 = asr(sq4_ff, 5'd12);
   always_ff @(posedge clock) begin
      b2sq5_ff  <= 32'(b2 * b6sq5);
      b1sq5_ff  <= 32'(b1 * b6sq5);
      a2b6_5_ff <= a2b6_4_ff;
      a3b6_5_ff <= a3b6_4_ff;
      temp5_ff  <= temp4_ff;
      up5_ff    <= up4_ff;
      err5_ff   <= err4_ff;
   end

   // b3 and sensitivity sum
   logic [31:0] x3_6, v6, xb6;
   logic [31:0] b3_6_ff, xb6_ff;
   logic [27:0] temp6_ff;
   logic [18:0] up6_ff;
   logic        err6_ff;
   assign x3_6 = asr(b2sq5_ff, 5'd11) + asr(a2b6_5_ff, 5'd11);
   assign v6   = (((a1 << 2) + x3_6) << oss_ff) + 32'd2;
   assign xb6  = asr(asr(a3b6_5_ff, 5'd13) + asr(b1sq5_ff, 5'd16) + 32'd2, 5'd2);
   always_ff @(posedge clock) begin
      b3_6_ff  <= asr(v6 + (v6[31] ? 32'd3 : 32'd0), 5'd2);
      xb6_ff   <= xb6;
      temp6_ff <= temp5_ff;
      up6_ff   <= up5_ff;
      err6_ff  <= err5_ff;
   end

   // b4 product and pressure difference
   logic [31:0] prod7_ff, diff7_ff;
   logic [27:0] temp7_ff;
   logic        err7_ff;
   always_ff @(posedge clock) begin
      prod7_ff <= 32'(a4 * (xb6_ff + B4_BIAS));
      diff7_ff <= {13'd0, up6_ff} - b3_6_ff;
      temp7_ff <= temp6_ff;
      err7_ff  <= err6_ff;
   end

   // b4 and b7
   logic [31:0] b4_8_ff, b7_8_ff;
   logic [27:0] temp8_ff;
   logic        err8_ff;
   always_ff @(posedge clock) begin
      b4_8_ff  <= prod7_ff >> 15;
      b7_8_ff  <= 32'(diff7_ff * (B7_SCALE >> oss_ff));
      temp8_ff <= temp7_ff;
      err8_ff  <= err7_ff || (prod7_ff[31:15] == '0);
   end

   // pressure division, split branch when b7 has its top bit set
   logic [31:0]        num8;
   logic               split8;
   logic [31:0]        q2;
   logic [D2_SIDE-1:0] s2;
   assign split8 = b7_8_ff[31];
   assign num8   = split8 ? b7_8_ff : (b7_8_ff << 1);

   bptc_div #(.SIDE_W(D2_SIDE)) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v8_ff),
      .in_num    (num8),
      .in_den    (b4_8_ff),
      .in_side   ({temp8_ff, split8, err8_ff}),
      .out_valid (d2_valid),
      .out_quo   (q2),
      .out_side  (s2)
   );

   // trim products
   logic [31:0] p9, p8_9;
   logic [31:0] p9_ff, sq9_ff, lin9_ff;
   logic [27:0] temp9_ff;
   logic        err9_ff;
   assign p9   = s2[1] ? (q2 << 1) : q2;
   assign p8_9 = asr(p9, 5'd8);
   always_ff @(posedge clock) begin
      p9_ff    <= p9;
      sq9_ff   <= 32'(p8_9 * p8_9);
      lin9_ff  <= 32'(TRIM_LIN * p9);
      temp9_ff <= s2[29:2];
      err9_ff  <= s2[0];
   end

   logic [31:0] p10_ff, t10_ff, lin10_ff;
   logic [27:0] temp10_ff;
   logic        err10_ff;
   always_ff @(posedge clock) begin
      p10_ff    <= p9_ff;
      t10_ff    <= 32'(sq9_ff * TRIM_SQ);
      lin10_ff  <= lin9_ff;
      temp10_ff <= temp9_ff;
      err10_ff  <= err9_ff;
   end

   // final trim and output register
   logic [31:0]  pfin;
   rsp_data_type rsp_in;
   rsp_data_type rsp_data_ff;
   assign pfin = p10_ff
               + asr(asr(t10_ff, 5'd16) + asr(lin10_ff, 5'd16) + TRIM_OFS, 5'd4);

   always_comb begin
      rsp_in.temperature  = err10_ff ? '0 : temp10_ff;
      rsp_in.pressure     = err10_ff ? '0 : pfin;
      rsp_in.divide_error = err10_ff;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY + 1))
      else $error("result without a matching start");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_error |->
         rsp_data.pressure == '0 && rsp_data.temperature == '0)
      else $error("divide error with nonzero result");

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      d2_valid |-> $past(v8_ff, DIV_W))
      else $error("pressure divider valid out of step");

endmodule

### hdl/bptc_div.sv
module bptc_div #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [31:0]       in_num,
   input  logic [31:0]       in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_quo,
   output logic [SIDE_W-1:0] out_side
);
   import bptc_pkg::*;

   localparam int N = DIV_W;

   logic [N-1:0]       vld_ff;
   logic [DIV_W-1:0]   rem_ff  [N];
   logic [DIV_W-1:0]   num_ff  [N];
   logic [DIV_W-1:0]   den_ff  [N];
   logic [SIDE_W-1:0]  side_ff [N];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic              pv;
      logic [DIV_W-1:0]  prem;
      logic [DIV_W-1:0]  pnum;
      logic [DIV_W-1:0]  pden;
      logic [SIDE_W-1:0] pside;
      logic [DIV_W:0]    trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign pnum  = in_num;
         assign pden  = in_den;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = vld_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign pnum  = num_ff[k-1];
         assign pden  = den_ff[k-1];
         assign pside = side_ff[k-1];
      end

      assign trial = {prem, pnum[DIV_W-1]};
      assign ge    = trial >= {1'b0, pden};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= ge ? DIV_W'(trial - {1'b0, pden}) : trial[DIV_W-1:0];
         num_ff[k]  <= {pnum[DIV_W-2:0], ge};
         den_ff[k]  <= pden;
         side_ff[k] <= pside;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = num_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### verif/baro_temp_pressure_compensation_core_tb.sv
module baro_temp_pressure_compensation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bptc_pkg::*;

   // holds compensation coefficients and predicted samples in start order
   class compensation_scoreboard;
      logic [31:0] coef [8];
      rsp_data_type pending_q [$];
      int errors;

      function void clear_coefs();
         foreach (coef[i]) coef[i] = '0;
      endfunction

      function void write_coef(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_A1, CSR_A2, CSR_A3, CSR_A4: coef[idx] = {16'd0, value[15:0]};
            CSR_OSS: coef[idx] = {30'd0, value[1:0]};
            default: coef[idx] = value;
         endcase
      endfunction

      function logic [31:0] shr_s(logic [31:0] x, int s);
         return 32'($signed(x) >>> s);
      endfunction

      function logic [31:0] ext16(logic [15:0] x);
         return {{16{x[15]}}, x};
      endfunction

      // signed division truncating toward zero, wrapping on overflow
      function logic [31:0] div_s(logic [31:0] a, logic [31:0] b);
         logic [31:0] ma, mb, q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q = ma / mb;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      // predict the compensated sample for one raw pair
      function void note_sample(req_data_type rq);
         rsp_data_type r;
         logic [31:0] ut, up, a1, a2, a3, a4, a5, a6, b1, b2, mc, md;
         logic [31:0] x1, x2, x3, den, b5, b6, b6sq, b3, b4, b7, p, t;
         int m;
         ut = {16'd0, rq.raw_temp};
         up = {13'd0, rq.raw_pressure};
         m = coef[CSR_OSS][1:0];
         a1 = ext16(coef[CSR_A1][15:0]);
         a2 = ext16(coef[CSR_A2][15:0]);
         a3 = ext16(coef[CSR_A3][15:0]);
         a4 = {16'd0, coef[CSR_A4][15:0]};
         a5 = {16'd0, coef[CSR_A5_A6][31:16]};
         a6 = {16'd0, coef[CSR_A5_A6][15:0]};
         b1 = ext16(coef[CSR_B1_B2][31:16]);
         b2 = ext16(coef[CSR_B1_B2][15:0]);
         mc = ext16(coef[CSR_C_D][31:16]);
         md = ext16(coef[CSR_C_D][15:0]);
         r = '0;
         r.divide_error = 1'b1;
         x1 = shr_s((ut - a6) * a5, 15);
         den = x1 + md;
         if (den != 0) begin
            x2 = div_s(mc << 11, den);
            b5 = x1 + x2;
            t = shr_s(b5 + 32'd8, 4);
            b6 = b5 - 32'd4000;
            b6sq = shr_s(b6 * b6, 12);
            x1 = shr_s(b2 * b6sq, 11);
            x2 = shr_s(a2 * b6, 11);
            x3 = x1 + x2;
            b3 = div_s(((a1 * 32'd4 + x3) << m) + 32'd2, 32'd4);
            x1 = shr_s(a3 * b6, 13);
            x2 = shr_s(b1 * b6sq, 16);
            x3 = shr_s(x1 + x2 + 32'd2, 2);
            b4 = (a4 * (x3 + 32'd32768)) >> 15;
            if (b4 != 0) begin
               b7 = (up - b3) * (32'd50000 >> m);
               if (!b7[31]) p = (b7 * 32'd2) / b4;
               else p = (b7 / b4) * 32'd2;
               x1 = shr_s(p, 8) * shr_s(p, 8);
               x1 = shr_s(x1 * 32'd3038, 16);
               x2 = shr_s(32'hFFFF_E343 * p, 16);
               p = p + shr_s(x1 + x2 + 32'd3791, 4);
               r.temperature = t[27:0];
               r.pressure = p;
               r.divide_error = 1'b0;
            end
         end
         pending_q.push_back(r);
      endfunction

      function void check_sample(rsp_data_type act);
         rsp_data_type exp_r;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $realtime, act);
            errors++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (act.temperature !== exp_r.temperature)
            $display("%0t: temperature mismatch, expected %0d actual %0d",
                     $realtime, exp_r.temperature, act.temperature);
         if (act.pressure !== exp_r.pressure)
            $display("%0t: pressure mismatch, expected %0d actual %0d",
                     $realtime, exp_r.pressure, act.pressure);
         if (act.divide_error !== exp_r.divide_error)
            $display("%0t: divide_error mismatch, expected %0d actual %0d",
                     $realtime, exp_r.divide_error, act.divide_error);
         if (act !== exp_r) errors++;
      endfunction
   endclass

   localparam int LATENCY     = 75;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_data_type req_data = '0;
   logic rsp_valid;
   rsp_data_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   compensation_scoreboard sb = new();
   int cycle_count = 0;
   int sample_count = 0;
   int error_results = 0;

   baro_temp_pressure_compensation_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result monitor and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (rsp_data.divide_error) error_results++;
         sb.check_sample(rsp_data);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("baro_temp_pressure_compensation_core_tb: done, errors");
         $finish;
      end
   end

   // one register write, then csr_we is dropped again before the task returns
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_coef(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // start one transaction, holding start across back-to-back items
   task automatic send_sample(logic [15:0] ut, logic [18:0] up, bit keep);
      req_data_type rq;
      rq.raw_temp = ut;
      rq.raw_pressure = up;
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      sb.note_sample(rq);
      sample_count++;
      if (!keep) start <= 1'b0;
   endtask

   task automatic random_gap();
      int g;
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g != 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // datasheet-like coefficient set with small random spread
   task automatic program_typical(logic [1:0] oss);
      csr_write(CSR_A1, 32'(16'(408 + $urandom_range(0, 200))));
      csr_write(CSR_A2, 32'(-16'sd72 - 16'($urandom_range(0, 50))));
      csr_write(CSR_A3, 32'(-16'sd14383 + 16'($urandom_range(0, 500))));
      csr_write(CSR_A4, 32'(32741 + $urandom_range(0, 500)));
      csr_write(CSR_A5_A6, {16'(32757 + $urandom_range(0, 50)),
                            16'(23153 + $urandom_range(0, 50))});
      csr_write(CSR_B1_B2, {16'sd6190, 16'sd4});
      csr_write(CSR_C_D, {16'(-16'sd8711), 16'sd2868});
      csr_write(CSR_OSS, {30'd0, oss});
   endtask

   task automatic program_random();
      for (int i = 0; i < 8; i++)
         csr_write(3'(i), $urandom());
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         logic [15:0] ut;
         logic [18:0] up;
         if ($urandom_range(0, 4) != 0) begin
            ut = 16'($urandom_range(20000, 35000));
            up = 19'($urandom_range(20000, 400000));
         end else begin
            ut = 16'($urandom());
            up = 19'($urandom());
         end
         send_sample(ut, up, 1'b1);
         random_gap();
      end
      start <= 1'b0;
      @(posedge clock);
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients: temperature divisor is zero
      send_sample(16'h0000, 19'h00000, 1'b1);
      send_sample(16'hFFFF, 19'h7FFFF, 1'b0);
      wait_drained();

      // directed: typical set, field extremes, all oversampling modes
      for (int m = 0; m < 4; m++) begin
         program_typical(2'(m));
         send_sample(16'h0000, 19'h00000, 1'b1);
         send_sample(16'hFFFF, 19'h7FFFF, 1'b1);
         send_sample(16'd27898, 19'd23843, 1'b1);
         send_sample(16'h5555, 19'h2AAAA, 1'b0);
         wait_drained();
      end

      // temperature divisor zero: a5 = 0 so x1 = 0, md = 0
      csr_write(CSR_A5_A6, 32'h0000_1234);
      csr_write(CSR_C_D, 32'h1000_0000);
      send_sample(16'd100, 19'd1000, 1'b0);
      wait_drained();

      // pressure divisor zero: a4 = 0
      program_typical(2'd0);
      csr_write(CSR_A4, 32'd0);
      send_sample(16'd27898, 19'd23843, 1'b0);
      wait_drained();

      // extreme signed coefficients, quotient overflow territory
      csr_write(CSR_A1, 32'h0000_8000);
      csr_write(CSR_A2, 32'h0000_7FFF);
      csr_write(CSR_A3, 32'h0000_8000);
      csr_write(CSR_A4, 32'h0000_FFFF);
      csr_write(CSR_A5_A6, 32'hFFFF_FFFF);
      csr_write(CSR_B1_B2, 32'h8000_7FFF);
      csr_write(CSR_C_D, 32'h8000_0001);
      csr_write(CSR_OSS, 32'd3);
      send_sample(16'h0000, 19'h7FFFF, 1'b1);
      send_sample(16'hFFFF, 19'h00000, 1'b1);
      send_sample(16'h8000, 19'h40000, 1'b0);
      wait_drained();

      // random phases: mostly realistic coefficients, some fully random
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 2) program_random();
         else program_typical(2'($urandom_range(0, 3)));
         random_phase(72);
      end

      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d samples over typical, random and extreme coefficient sets", sample_count);
      $display("%0d of them hit a zero divisor, all oversampling modes used", error_results);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("baro_temp_pressure_compensation_core_tb: done, clean");
      else
         $display("baro_temp_pressure_compensation_core_tb: done, errors");
      $finish;
   end
endmodule
